// File: rtl/c16pf_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the packet framer.
`timescale 1ns / 1ps
package c16pf_pkg;

  localparam int IDX_W      = 5;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  SYNC_CHAR    = 8'h23;
  localparam logic [7:0]  HDR_MARK     = 8'hFF;
  localparam logic [7:0]  PKT_TYPE     = 8'd18;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] LEN_OVERHEAD = 16'd19;

  // Byte positions within one run of output beats
  localparam logic [IDX_W-1:0] IDX_FIRST    = 5'd0;
  localparam logic [IDX_W-1:0] IDX_HDR_LAST = 5'd16;
  localparam logic [IDX_W-1:0] IDX_HDR_CRCH = 5'd17;
  localparam logic [IDX_W-1:0] IDX_HDR_CRCL = 5'd18;
  localparam logic [IDX_W-1:0] IDX_DAT_CRCH = 5'd1;
  localparam logic [IDX_W-1:0] IDX_DAT_CRCL = 5'd2;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_SERIAL_PREFIX = 1'b0,
    REG_SERIAL_NUMBER = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_packet;
  } beat_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/c16pf_in_if.sv
// Input item channel: valid/ready handshake with start and data fields.
`timescale 1ns / 1ps
interface c16pf_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] measurement_number;
  logic [15:0] device_type;
  logic [31:0] device_serial;
  logic [7:0]  exception_code;
  logic [7:0]  result_length;
  logic [7:0]  data_byte;

  modport source (
    output valid, command, measurement_number, device_type, device_serial,
    output exception_code, result_length, data_byte,
    input  ready
  );

  modport sink (
    input  valid, command, measurement_number, device_type, device_serial,
    input  exception_code, result_length, data_byte,
    output ready
  );
endinterface

// File: rtl/c16pf_out_if.sv
// Output byte channel: valid/ready handshake carrying one packet byte per beat.
`timescale 1ns / 1ps
interface c16pf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_packet;

  modport source (
    output valid, out_byte, last_of_run, end_of_packet,
    input  ready
  );

  modport sink (
    input  valid, out_byte, last_of_run, end_of_packet,
    output ready
  );
endinterface

// File: rtl/crc16_packet_framer.sv
// Measurement packet framer with CRC-16/MODBUS trailer: top level.
//
// One output beat per cycle while the sink is ready. A data item gives one
// byte, or three when it is the last data byte and the two CRC bytes
// follow; a start item gives the 17 header bytes, or 19 with a zero
// result length. A data item with no packet open is dropped without a beat.
// The next item is taken in the same cycle as the last beat of the current
// one, so the single byte-wide output register sets the rate. No clearing
// pass after reset.
`timescale 1ns / 1ps
module crc16_packet_framer (
  input  logic                              clk,
  input  logic                              rst_n,
  c16pf_in_if.sink                          in_ch,
  c16pf_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [c16pf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  c16pf_pkg::beat_t beat;
  logic             beat_valid;
  logic             beat_ready;

  c16pf_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .beat       (beat),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready)
  );

  c16pf_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (beat),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .out_ch     (out_ch)
  );

endmodule

// File: rtl/c16pf_seq.sv
// Item register, byte sequencer, CRC state and configuration registers.
`timescale 1ns / 1ps
module c16pf_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  c16pf_in_if.sink                          in_ch,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [c16pf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output c16pf_pkg::beat_t                  beat,
  output logic                              beat_valid,
  input  logic                              beat_ready
);

  logic                          item_valid_r, item_valid_nxt;
  c16pf_pkg::cmd_t               cmd_r;
  logic [15:0]                   meas_r;
  logic [15:0]                   dtype_r;
  logic [31:0]                   dser_r;
  logic [7:0]                    exc_r;
  logic [7:0]                    rlen_r;
  logic [7:0]                    data_r;
  logic [c16pf_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [15:0]                   crc_r, crc_nxt;
  logic [7:0]                    rem_r, rem_nxt;
  logic                          open_r, open_nxt;
  logic [7:0]                    prefix_r;
  logic [15:0]                   serial_r;

  logic        skip, emit, fire, last, eop, accept, retire;
  logic [7:0]  cur_byte;
  logic [15:0] total_len;
  logic        is_start;

  assign is_start  = (cmd_r == c16pf_pkg::CMD_START);
  assign total_len = c16pf_pkg::LEN_OVERHEAD + {8'h00, rlen_r};

  // Data beats with no open packet produce nothing: drop them
  assign skip   = item_valid_r && !is_start && (idx_r == c16pf_pkg::IDX_FIRST) &&
                  (!open_r || rem_r == 8'h00);
  assign emit   = item_valid_r && !skip;
  assign fire   = emit && beat_ready;
  assign retire = skip || (fire && last);
  assign in_ch.ready = !item_valid_r || retire;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    cur_byte = 8'h00;
    last     = 1'b0;
    eop      = 1'b0;
    if (is_start) begin
      case (idx_r)
        5'd0:    cur_byte = c16pf_pkg::SYNC_CHAR;
        5'd1:    cur_byte = prefix_r;
        5'd2:    cur_byte = serial_r[15:8];
        5'd3:    cur_byte = serial_r[7:0];
        5'd4:    cur_byte = c16pf_pkg::HDR_MARK;
        5'd5:    cur_byte = c16pf_pkg::PKT_TYPE;
        5'd6:    cur_byte = total_len[15:8];
        5'd7:    cur_byte = total_len[7:0];
        5'd8:    cur_byte = meas_r[15:8];
        5'd9:    cur_byte = meas_r[7:0];
        5'd10:   cur_byte = dtype_r[15:8];
        5'd11:   cur_byte = dtype_r[7:0];
        5'd12:   cur_byte = dser_r[31:24];
        5'd13:   cur_byte = dser_r[23:16];
        5'd14:   cur_byte = dser_r[15:8];
        5'd15:   cur_byte = dser_r[7:0];
        5'd16:   cur_byte = exc_r;
        5'd17:   cur_byte = crc_r[15:8];
        5'd18:   cur_byte = crc_r[7:0];
        default: cur_byte = 8'h00;
      endcase
      last = (idx_r == c16pf_pkg::IDX_HDR_LAST && rlen_r != 8'h00) ||
             (idx_r == c16pf_pkg::IDX_HDR_CRCL);
      eop  = (idx_r == c16pf_pkg::IDX_HDR_CRCL);
    end else begin
      if (idx_r == c16pf_pkg::IDX_DAT_CRCH) begin
        cur_byte = crc_r[15:8];
      end else if (idx_r == c16pf_pkg::IDX_DAT_CRCL) begin
        cur_byte = crc_r[7:0];
      end else begin
        cur_byte = data_r;
      end
      last = (idx_r == c16pf_pkg::IDX_FIRST && rem_r != 8'h01) ||
             (idx_r == c16pf_pkg::IDX_DAT_CRCL);
      eop  = (idx_r == c16pf_pkg::IDX_DAT_CRCL);
    end
  end

  assign beat_valid         = emit;
  assign beat.out_byte      = cur_byte;
  assign beat.last_of_run   = last;
  assign beat.end_of_packet = eop;

  always_comb begin
    item_valid_nxt = item_valid_r;
    idx_nxt        = idx_r;
    crc_nxt        = crc_r;
    rem_nxt        = rem_r;
    open_nxt       = open_r;
    if (retire) begin
      item_valid_nxt = 1'b0;
    end
    if (fire) begin
      idx_nxt = idx_r + 5'd1;
      if (is_start) begin
        if (idx_r == c16pf_pkg::IDX_FIRST) begin
          crc_nxt  = c16pf_pkg::CRC_INIT;
          rem_nxt  = rlen_r;
          open_nxt = 1'b1;
        end else if (idx_r <= c16pf_pkg::IDX_HDR_LAST) begin
          crc_nxt = c16pf_pkg::crc16_byte(crc_r, cur_byte);
        end
      end else if (idx_r == c16pf_pkg::IDX_FIRST) begin
        crc_nxt = c16pf_pkg::crc16_byte(crc_r, cur_byte);
        rem_nxt = rem_r - 8'h01;
      end
      // Close the packet after its final CRC byte
      if (eop) begin
        open_nxt = 1'b0;
        rem_nxt  = 8'h00;
      end
    end
    if (accept) begin
      item_valid_nxt = 1'b1;
      idx_nxt        = c16pf_pkg::IDX_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      idx_r        <= c16pf_pkg::IDX_FIRST;
      crc_r        <= c16pf_pkg::CRC_INIT;
      rem_r        <= 8'h00;
      open_r       <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      idx_r        <= idx_nxt;
      crc_r        <= crc_nxt;
      rem_r        <= rem_nxt;
      open_r       <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= c16pf_pkg::cmd_t'(in_ch.command);
      meas_r  <= in_ch.measurement_number;
      dtype_r <= in_ch.device_type;
      dser_r  <= in_ch.device_serial;
      exc_r   <= in_ch.exception_code;
      rlen_r  <= in_ch.result_length;
      data_r  <= in_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= 8'h00;
      serial_r <= 16'h0000;
    end else if (cfg_we) begin
      unique case (c16pf_pkg::reg_idx_t'(cfg_index))
        c16pf_pkg::REG_SERIAL_PREFIX: prefix_r <= cfg_data[7:0];
        c16pf_pkg::REG_SERIAL_NUMBER: serial_r <= cfg_data;
        default: ;
      endcase
    end
  end

  a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (open_r && rem_r == 8'h00) |-> item_valid_r)
    else $error("open packet with no bytes remaining and no CRC pending");

  a_eop_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && eop) |=> !open_r)
    else $error("packet still open after final CRC byte");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r |-> idx_r <= c16pf_pkg::IDX_HDR_CRCL)
    else $error("byte index out of range");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> item_valid_r && idx_r == c16pf_pkg::IDX_FIRST)
    else $error("accepted item not loaded at first byte");

  a_eop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && eop) |-> last)
    else $error("end of packet not flagged as last of run");

endmodule

// File: rtl/c16pf_out_reg.sv
// Output register between the byte sequencer and the result channel.
`timescale 1ns / 1ps
module c16pf_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  c16pf_pkg::beat_t  beat,
  input  logic              beat_valid,
  output logic              beat_ready,
  c16pf_out_if.source       out_ch
);

  logic             valid_r, valid_nxt;
  c16pf_pkg::beat_t beat_r;

  assign beat_ready = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (beat_ready) begin
      valid_nxt = beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the beat while the sink stalls
  always_ff @(posedge clk) begin
    if (beat_ready && beat_valid) begin
      beat_r <= beat;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.out_byte      = beat_r.out_byte;
  assign out_ch.last_of_run   = beat_r.last_of_run;
  assign out_ch.end_of_packet = beat_r.end_of_packet;

endmodule

// File: test/tb.sv
// Self-checking testbench for the CRC-16 measurement packet framer.
`timescale 1ns / 1ps
module tb;

  typedef struct {
    c16pf_pkg::cmd_t command;
    logic [15:0]     measurement_number;
    logic [15:0]     device_type;
    logic [31:0]     device_serial;
    logic [7:0]      exception_code;
    logic [7:0]      result_length;
    logic [7:0]      data_byte;
  } frame_item_t;

  class packet_scoreboard;
    logic [7:0]       prefix;
    logic [15:0]      serial;
    logic [15:0]      crc;
    logic [7:0]       remaining;
    bit               open;
    c16pf_pkg::beat_t pending_bytes[$];
    int               fail_count;
    int               beats_checked;
    int               packets_opened;
    int               packets_closed;
    int               aborts;

    function new();
      prefix         = '0;
      serial         = '0;
      crc            = c16pf_pkg::CRC_INIT;
      remaining      = '0;
      open           = 1'b0;
      fail_count     = 0;
      beats_checked  = 0;
      packets_opened = 0;
      packets_closed = 0;
      aborts         = 0;
    endfunction

    function void set_regs(logic [7:0] p, logic [15:0] s);
      prefix = p;
      serial = s;
    endfunction

    // Bitwise form of the reflected 0xA001 update, one data bit per step
    function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c;
      for (int k = 0; k < 8; k++) begin
        if (r[0] ^ b[k]) begin
          r = (r >> 1) ^ c16pf_pkg::CRC_POLY;
        end else begin
          r = r >> 1;
        end
      end
      return r;
    endfunction

    function void push_byte(logic [7:0] b, logic eop);
      c16pf_pkg::beat_t e;
      e.out_byte      = b;
      e.last_of_run   = 1'b0;
      e.end_of_packet = eop;
      pending_bytes.push_back(e);
    endfunction

    function void close_packet();
      push_byte(crc[15:8], 1'b0);
      push_byte(crc[7:0], 1'b1);
      open      = 1'b0;
      remaining = '0;
      packets_closed++;
    endfunction

    // Predict the beats caused by one accepted item; returns how many
    function int note_item(frame_item_t it);
      logic [7:0]  hdr[17];
      logic [15:0] total;
      int          start_size;
      start_size = pending_bytes.size();
      if (it.command == c16pf_pkg::CMD_START) begin
        if (open) aborts++;
        total   = c16pf_pkg::LEN_OVERHEAD + {8'h00, it.result_length};
        hdr[0]  = c16pf_pkg::SYNC_CHAR;
        hdr[1]  = prefix;
        hdr[2]  = serial[15:8];
        hdr[3]  = serial[7:0];
        hdr[4]  = c16pf_pkg::HDR_MARK;
        hdr[5]  = c16pf_pkg::PKT_TYPE;
        hdr[6]  = total[15:8];
        hdr[7]  = total[7:0];
        hdr[8]  = it.measurement_number[15:8];
        hdr[9]  = it.measurement_number[7:0];
        hdr[10] = it.device_type[15:8];
        hdr[11] = it.device_type[7:0];
        hdr[12] = it.device_serial[31:24];
        hdr[13] = it.device_serial[23:16];
        hdr[14] = it.device_serial[15:8];
        hdr[15] = it.device_serial[7:0];
        hdr[16] = it.exception_code;
        // sync char is not covered by the CRC
        crc = c16pf_pkg::CRC_INIT;
        for (int i = 0; i < 17; i++) begin
          if (i > 0) crc = crc_update(crc, hdr[i]);
          push_byte(hdr[i], 1'b0);
        end
        remaining = it.result_length;
        open      = 1'b1;
        packets_opened++;
        if (it.result_length == 8'd0) close_packet();
      end else begin
        // drop data with no packet open
        if (!open || remaining == 8'd0) return 0;
        crc = crc_update(crc, it.data_byte);
        push_byte(it.data_byte, 1'b0);
        remaining--;
        if (remaining == 8'd0) close_packet();
      end
      pending_bytes[pending_bytes.size() - 1].last_of_run = 1'b1;
      return pending_bytes.size() - start_size;
    endfunction

    function void report(string what);
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] MISMATCH beat %0d: %s", $realtime, beats_checked, what);
    endfunction

    function void check_beat(c16pf_pkg::beat_t got);
      c16pf_pkg::beat_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected beat byte=%02h last=%0b eop=%0b",
                         got.out_byte, got.last_of_run, got.end_of_packet));
      end else begin
        want = pending_bytes.pop_front();
        if (got.out_byte !== want.out_byte)
          report($sformatf("out_byte exp %02h got %02h", want.out_byte, got.out_byte));
        if (got.last_of_run !== want.last_of_run)
          report($sformatf("last_of_run exp %0b got %0b", want.last_of_run, got.last_of_run));
        if (got.end_of_packet !== want.end_of_packet)
          report($sformatf("end_of_packet exp %0b got %0b",
                           want.end_of_packet, got.end_of_packet));
      end
      beats_checked++;
    endfunction

    function void final_check();
      if (pending_bytes.size() != 0)
        report($sformatf("%0d expected beats never arrived", pending_bytes.size()));
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [0:0]                       cfg_index;
  logic [c16pf_pkg::CFG_DATA_W-1:0] cfg_data;

  c16pf_in_if  in_ch();
  c16pf_out_if out_ch();

  crc16_packet_framer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  packet_scoreboard sb;
  bit squeeze_req;
  int items_sent;
  int items_dropped;
  int tx_free_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("Timeout: beats still outstanding");
    $display("Test completed with failures");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // Receiver: random stalls, free-running stretches, one long hold-off on request
  initial begin
    int stall_left;
    int free_left;
    stall_left  = 0;
    free_left   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        stall_left  = 120;
        free_left   = 0;
      end
      if (stall_left == 0 && free_left == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          free_left = $urandom_range(20, 60);
        end else if ($urandom_range(0, 2) == 0) begin
          stall_left = gap_len();
        end
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (free_left > 0) free_left--;
      end
    end
  end

  // Output monitor
  initial begin
    c16pf_pkg::beat_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.out_byte      = out_ch.out_byte;
        got.last_of_run   = out_ch.last_of_run;
        got.end_of_packet = out_ch.end_of_packet;
        sb.check_beat(got);
      end
    end
  end

  function automatic frame_item_t make_start(logic [15:0] meas, logic [15:0] dtype,
                                             logic [31:0] dser, logic [7:0] exc,
                                             logic [7:0] rlen);
    frame_item_t it;
    it.command            = c16pf_pkg::CMD_START;
    it.measurement_number = meas;
    it.device_type        = dtype;
    it.device_serial      = dser;
    it.exception_code     = exc;
    it.result_length      = rlen;
    it.data_byte          = 8'($urandom());
    return it;
  endfunction

  function automatic frame_item_t make_data(logic [7:0] d);
    frame_item_t it;
    it.command            = c16pf_pkg::CMD_DATA;
    it.measurement_number = 16'($urandom());
    it.device_type        = 16'($urandom());
    it.device_serial      = $urandom();
    it.exception_code     = 8'($urandom());
    it.result_length      = 8'($urandom());
    it.data_byte          = d;
    return it;
  endfunction

  // Called at a rising edge; returns at the edge that accepted the beat
  task automatic send_item(frame_item_t it);
    if (tx_free_left > 0) begin
      tx_free_left--;
    end else if ($urandom_range(0, 11) == 0) begin
      tx_free_left = $urandom_range(15, 40);
    end else if ($urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.command            <= it.command;
    in_ch.measurement_number <= it.measurement_number;
    in_ch.device_type        <= it.device_type;
    in_ch.device_serial      <= it.device_serial;
    in_ch.exception_code     <= it.exception_code;
    in_ch.result_length      <= it.result_length;
    in_ch.data_byte          <= it.data_byte;
    do @(posedge clk); while (!in_ch.ready);
    if (sb.note_item(it) > 0) begin
      items_sent++;
    end else begin
      items_dropped++;
    end
  endtask

  // Let the block go idle: all beats out, then a wait for dropped items
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_bytes.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(logic [7:0] p, logic [15:0] s);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= c16pf_pkg::REG_SERIAL_PREFIX;
    cfg_data  <= {8'h00, p};
    @(posedge clk);
    cfg_index <= c16pf_pkg::REG_SERIAL_NUMBER;
    cfg_data  <= s;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_regs(p, s);
  endtask

  task automatic send_packet(logic [7:0] rlen, int n_data);
    send_item(make_start(16'($urandom()), 16'($urandom()), $urandom(),
                         8'($urandom()), rlen));
    repeat (n_data) send_item(make_data(8'($urandom())));
  endtask

  task automatic run_random(int budget);
    int   target;
    int   pick;
    int   n_data;
    logic [7:0] rlen;
    target = items_sent + budget;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_item(make_data(8'($urandom())));
      end else begin
        if (pick < 80) rlen = 8'($urandom_range(0, 6));
        else if (pick < 96) rlen = 8'($urandom_range(7, 24));
        else rlen = 8'($urandom_range(200, 255));
        // abort long packets and some short ones part way through with a fresh start
        if (rlen > 8'd24 || (rlen > 8'd0 && $urandom_range(0, 7) == 0)) begin
          n_data = $urandom_range(0, (rlen > 8'd8) ? 8 : int'(rlen) - 1);
          send_packet(rlen, n_data);
        end else begin
          send_packet(rlen, int'(rlen));
        end
      end
    end
  endtask

  initial begin
    sb             = new();
    squeeze_req    = 1'b0;
    items_sent     = 0;
    items_dropped  = 0;
    tx_free_left   = 0;
    rst_n                    <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_index                <= c16pf_pkg::REG_SERIAL_PREFIX;
    cfg_data                 <= '0;
    in_ch.valid              <= 1'b0;
    in_ch.command            <= c16pf_pkg::CMD_START;
    in_ch.measurement_number <= '0;
    in_ch.device_type        <= '0;
    in_ch.device_serial      <= '0;
    in_ch.exception_code     <= '0;
    in_ch.result_length      <= '0;
    in_ch.data_byte          <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, zero length, last byte, abort, stray data
    write_regs(8'hFF, 16'hFFFF);
    send_item(make_data(8'hFF));
    send_item(make_start(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'd0));
    send_item(make_start(16'h0000, 16'h0000, 32'h0000_0000, 8'h00, 8'd0));
    send_item(make_start(16'hA5A5, 16'h5A5A, 32'hA5A5_5A5A, 8'hA5, 8'd1));
    send_item(make_data(8'h00));
    send_item(make_start(16'h5A5A, 16'hA5A5, 32'h5A5A_A5A5, 8'h5A, 8'd255));
    send_item(make_data(8'hFF));
    send_item(make_data(8'h80));
    send_item(make_start(16'h8001, 16'h0180, 32'h8000_0001, 8'h81, 8'd3));
    send_item(make_data(8'h01));
    send_item(make_data(8'hFE));
    send_item(make_data(8'h7F));
    send_item(make_data(8'h55));
    send_item(make_start(16'h1234, 16'hFEDC, 32'h0123_4567, 8'h00, 8'd2));
    send_item(make_data(8'hAA));
    send_item(make_start(16'hFFFF, 16'h0000, 32'hFFFF_0000, 8'hFF, 8'd1));
    send_item(make_data(8'h00));

    write_regs(8'h00, 16'h0000);
    run_random(25);

    write_regs(8'($urandom()), 16'($urandom()));
    // long receiver hold-off while a packet keeps streaming in
    squeeze_req = 1'b1;
    send_packet(8'd40, 40);
    run_random(25);

    write_regs(8'($urandom()), 16'($urandom()));
    run_random(25);

    drain();
    repeat (20) @(posedge clk);
    sb.final_check();
    $display("Covered %0d items (%0d dropped), %0d beats, %0d packets opened, %0d closed",
             items_sent, items_dropped, sb.beats_checked, sb.packets_opened,
             sb.packets_closed);
    $display("Restarted %0d open packets, %0d failures", sb.aborts, sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/c16pf_pkg.sv
rtl/c16pf_in_if.sv
rtl/c16pf_out_if.sv
rtl/c16pf_seq.sv
rtl/c16pf_out_reg.sv
rtl/crc16_packet_framer.sv
test/tb.sv
